// File: rtl/polygon_stroke_geometry_core_defines.svh
// Assertion macros for the stroke geometry core checker.
`ifndef POLYGON_STROKE_GEOMETRY_CORE_DEFINES_SVH
`define POLYGON_STROKE_GEOMETRY_CORE_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define PSG_ASSERT_NOW(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("check failed");

// Condition holds in the cycle after the trigger.
`define PSG_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("check failed");

`endif

// File: rtl/psg_pkg.sv
// Shared types, constants and circle table for the stroke geometry core.
package psg_pkg;

  localparam int unsigned MaxVerticesDef  = 4096;
  localparam int unsigned JoinSegmentsDef = 32;
  localparam logic [11:0] StrokeWidthRst  = 12'd160;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 64;
  localparam int unsigned OutUserW = 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_MULX,
    ST_DIVX,
    ST_MULY,
    ST_DIVY,
    ST_QUAD,
    ST_JOIN
  } st_e;

  // sin of k*pi/16 in Q1.14, quarter wave
  localparam logic [14:0] SinOct [9] = '{
    15'd0, 15'd3197, 15'd6270, 15'd9103, 15'd11585,
    15'd13623, 15'd15137, 15'd16069, 15'd16384
  };

  function automatic logic signed [15:0] sin_step(input logic [4:0] k);
    logic [14:0] m;
    logic        neg;
    begin
      neg = k[4] && (k != 5'd16);
      if (k <= 5'd8) begin
        m = SinOct[k[3:0]];
      end else if (k <= 5'd16) begin
        m = SinOct[4'(5'd16 - k)];
      end else if (k <= 5'd24) begin
        m = SinOct[4'(k - 5'd16)];
      end else begin
        m = SinOct[4'(6'd32 - {1'b0, k})];
      end
      sin_step = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    end
  endfunction

endpackage

// File: rtl/polygon_stroke_geometry_core.sv
// Stroke geometry core: round joins and edge quads for closed polygons.
//
//  channel  | dir | payload                                          | end
//  s_axis   | in  | tdata {py, px}, tlast last_vertex                | vertex
//  m_axis   | out | tdata {vertex_index, vy, vx}, tuser {deg, kind}  | last_result
//  cfg      | in  | cfg_data_i stroke_width                          | -
//
// One vertex at a time; input is ready only while idle. A join emits JOIN_SEGMENTS+1 vertices.
// An edge quad runs the squares, the bit-serial square root, then per axis the multiply
// and bit-serial normal divide, and emits four corners (a zero-length edge skips to them).
// Worst vertex: the last of a polygon, with an edge quad, its join and the closing edge quad.
// Output stalls hold the sequencer only in its emit states; the output register frees the input side.
// Reset: stroke width 160, awaiting first vertex.
module polygon_stroke_geometry_core #(
  parameter int unsigned MAX_VERTICES  = psg_pkg::MaxVerticesDef,
  parameter int unsigned JOIN_SEGMENTS = psg_pkg::JoinSegmentsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [psg_pkg::InDataW-1:0]   s_axis_tdata,  // px[15:0], py[31:16]
  input  logic                          s_axis_tlast,  // last_vertex
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [psg_pkg::OutDataW-1:0]  m_axis_tdata,  // vx[20:0], vy[41:21], idx[59:42]
  output logic [psg_pkg::OutUserW-1:0]  m_axis_tuser,  // vertex_kind[0], degenerate_edge[1]
  output logic                          m_axis_tlast,  // last_result
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [11:0]                   cfg_data_i     // stroke_width
);
  import psg_pkg::*;

  localparam int unsigned VCW   = $clog2(MAX_VERTICES);
  localparam int unsigned JCW   = $clog2(JOIN_SEGMENTS + 1);
  localparam int unsigned CW    = (JCW > 5) ? JCW : 5;
  localparam int unsigned PhInc = 32 / JOIN_SEGMENTS;
  localparam int unsigned PhRem = 32 % JOIN_SEGMENTS;
  localparam int unsigned FW    = $clog2(JOIN_SEGMENTS + 1);

  st_e state_q, state_d;

  logic [11:0]          h_q;
  logic signed [15:0]   first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [15:0]   cur_x_q, cur_y_q, qa_x_q, qa_y_q, qb_x_q, qb_y_q;
  logic [VCW-1:0]       count_q, vi_q, edge_q;
  logic                 in_poly_q, last_q, close_q, deg_q;
  logic [17:0]          jidx_q;
  logic [CW-1:0]        cnt_q;
  logic [4:0]           ph_q;
  logic [FW-1:0]        frac_q;
  logic [33:0]          sq_q;
  logic [49:0]          rv_q, rr_q;
  logic [48:0]          bit_q;
  logic [25:0]          rem_q;
  logic [12:0]          sh_q, quo_q;
  logic                 sgn_q;
  logic signed [13:0]   ox_q, oy_q;

  logic                 out_valid_q, out_last_q;
  logic [OutDataW-1:0]  out_data_q;
  logic [OutUserW-1:0]  out_user_q;

  logic                 in_acc, emit, adv, out_free;
  logic [VCW-1:0]       vi;
  logic signed [16:0]   dx, dy;
  logic [15:0]          adx, ady;
  logic [49:0]          r_try;
  logic [26:0]          div_t;
  logic                 div_ge;
  logic [12:0]          quo_n;
  logic [25:0]          div_d;
  logic [36:0]          num;
  logic signed [20:0]   o_vx, o_vy;
  logic [17:0]          o_idx;
  logic                 o_kind, o_last;
  logic signed [15:0]   cos_v, sin_v;
  logic [14:0]          cos_m, sin_m;
  logic [12:0]          cos_o, sin_o;
  logic signed [13:0]   cos_s, sin_s;
  logic signed [15:0]   cb_x, cb_y;
  logic signed [13:0]   co_x, co_y;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign adv           = emit && out_free;
  assign vi            = in_poly_q ? count_q : '0;

  assign dx    = {qb_x_q[15], qb_x_q} - {qa_x_q[15], qa_x_q};
  assign dy    = {qb_y_q[15], qb_y_q} - {qa_y_q[15], qa_y_q};
  assign adx   = 16'(dx[16] ? -dx : dx);
  assign ady   = 16'(dy[16] ? -dy : dy);
  assign r_try = rr_q + {1'b0, bit_q};
  assign div_d = {rr_q[24:0], 1'b0};
  assign div_t = {rem_q, sh_q[12]};
  assign div_ge = div_t >= {1'b0, div_d};
  assign quo_n = {quo_q[11:0], div_ge};
  assign num   = {({12'd0, (state_q == ST_MULX) ? ady : adx} * {16'd0, h_q}), 8'd0}
                 + {12'd0, rr_q[24:0]};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = in_poly_q ? ST_SQX : ST_JOIN;
      ST_SQX:  state_d = (dx == '0 && dy == '0) ? ST_QUAD : ST_SQY;
      ST_SQY:  state_d = ST_ROOT;
      ST_ROOT: if (cnt_q == CW'(24)) state_d = ST_MULX;
      ST_MULX: state_d = ST_DIVX;
      ST_DIVX: if (cnt_q == CW'(12)) state_d = ST_MULY;
      ST_MULY: state_d = ST_DIVY;
      ST_DIVY: if (cnt_q == CW'(12)) state_d = ST_QUAD;
      ST_QUAD: if (adv && cnt_q == CW'(3)) state_d = close_q ? ST_IDLE : ST_JOIN;
      ST_JOIN: if (adv && cnt_q == CW'(JOIN_SEGMENTS)) state_d = last_q ? ST_SQX : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // result values
  always_comb begin
    cos_v = sin_step(ph_q + 5'd8);
    sin_v = sin_step(ph_q);
    cos_m = 15'(cos_v[15] ? -cos_v : cos_v);
    sin_m = 15'(sin_v[15] ? -sin_v : sin_v);
    cos_o = 13'(({12'd0, cos_m} * {15'd0, h_q} + 27'd16384) >> 15);
    sin_o = 13'(({12'd0, sin_m} * {15'd0, h_q} + 27'd16384) >> 15);
    cos_s = cos_v[15] ? -$signed({1'b0, cos_o}) : $signed({1'b0, cos_o});
    sin_s = sin_v[15] ? -$signed({1'b0, sin_o}) : $signed({1'b0, sin_o});
    cb_x  = cnt_q[1] ? qb_x_q : qa_x_q;
    cb_y  = cnt_q[1] ? qb_y_q : qa_y_q;
    co_x  = cnt_q[0] ? -ox_q : ox_q;
    co_y  = cnt_q[0] ? -oy_q : oy_q;
    emit   = 1'b0;
    o_kind = 1'b0;
    o_last = 1'b0;
    o_vx   = '0;
    o_vy   = '0;
    o_idx  = '0;
    unique case (state_q)
      ST_QUAD: begin
        emit   = 1'b1;
        o_vx   = {cb_x[15], cb_x, 4'd0} + {{7{co_x[13]}}, co_x};
        o_vy   = {cb_y[15], cb_y, 4'd0} + {{7{co_y[13]}}, co_y};
        o_idx  = 18'({edge_q, cnt_q[1:0]});
        o_last = close_q && cnt_q == CW'(3);
      end
      ST_JOIN: begin
        emit   = 1'b1;
        o_kind = 1'b1;
        o_vx   = {cur_x_q[15], cur_x_q, 4'd0};
        o_vy   = {cur_y_q[15], cur_y_q, 4'd0};
        if (cnt_q != '0) begin
          o_vx = o_vx + {{7{cos_s[13]}}, cos_s};
          o_vy = o_vy + {{7{sin_s[13]}}, sin_s};
        end
        o_idx  = jidx_q;
        o_last = !last_q && cnt_q == CW'(JOIN_SEGMENTS);
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      h_q         <= StrokeWidthRst;
      first_x_q   <= '0;
      first_y_q   <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      count_q     <= '0;
      in_poly_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) h_q <= cfg_data_i;
      if (adv) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      if (in_acc) begin
        prev_x_q <= $signed(s_axis_tdata[15:0]);
        prev_y_q <= $signed(s_axis_tdata[31:16]);
        if (!in_poly_q) begin
          first_x_q <= $signed(s_axis_tdata[15:0]);
          first_y_q <= $signed(s_axis_tdata[31:16]);
        end
        if (s_axis_tlast) begin
          in_poly_q <= 1'b0;
          count_q   <= '0;
        end else begin
          in_poly_q <= 1'b1;
          count_q   <= (vi == VCW'(MAX_VERTICES - 1)) ? '0 : vi + 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {4'd0, o_idx, o_vy, o_vx};
      out_user_q <= {(o_kind ? 1'b0 : deg_q), o_kind};
      out_last_q <= o_last;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cur_x_q <= $signed(s_axis_tdata[15:0]);
          cur_y_q <= $signed(s_axis_tdata[31:16]);
          qa_x_q  <= prev_x_q;
          qa_y_q  <= prev_y_q;
          qb_x_q  <= $signed(s_axis_tdata[15:0]);
          qb_y_q  <= $signed(s_axis_tdata[31:16]);
          last_q  <= s_axis_tlast;
          close_q <= 1'b0;
          vi_q    <= vi;
          edge_q  <= (vi == '0) ? VCW'(MAX_VERTICES - 1) : vi - 1'b1;
          jidx_q  <= 18'(vi * (JOIN_SEGMENTS + 1));
          ph_q    <= '0;
          frac_q  <= '0;
          cnt_q   <= '0;
        end
      end
      ST_SQX: begin
        deg_q <= (dx == '0 && dy == '0);
        ox_q  <= '0;
        oy_q  <= '0;
        cnt_q <= '0;
        sq_q  <= 34'({16'd0, adx} * {16'd0, adx});
      end
      ST_SQY: begin
        rv_q  <= {sq_q + 34'({16'd0, ady} * {16'd0, ady}), 16'd0};
        rr_q  <= '0;
        bit_q <= {1'b1, 48'd0};
        cnt_q <= '0;
      end
      ST_ROOT: begin
        if (rv_q >= r_try) begin
          rv_q <= rv_q - r_try;
          rr_q <= (rr_q >> 1) + {1'b0, bit_q};
        end else begin
          rr_q <= rr_q >> 1;
        end
        bit_q <= bit_q >> 2;
        cnt_q <= cnt_q + 1'b1;
      end
      ST_MULX, ST_MULY: begin
        rem_q <= {2'd0, num[36:13]};
        sh_q  <= num[12:0];
        quo_q <= '0;
        cnt_q <= '0;
        sgn_q <= (state_q == ST_MULX) ? (!dy[16] && dy != '0) : dx[16];
      end
      ST_DIVX, ST_DIVY: begin
        rem_q <= div_ge ? 26'(div_t - {1'b0, div_d}) : div_t[25:0];
        sh_q  <= {sh_q[11:0], 1'b0};
        quo_q <= quo_n;
        cnt_q <= (cnt_q == CW'(12)) ? '0 : cnt_q + 1'b1;
        if (cnt_q == CW'(12)) begin
          if (state_q == ST_DIVX) ox_q <= sgn_q ? -$signed({1'b0, quo_n}) : $signed({1'b0, quo_n});
          else oy_q <= sgn_q ? -$signed({1'b0, quo_n}) : $signed({1'b0, quo_n});
        end
      end
      ST_QUAD: begin
        if (adv) cnt_q <= (cnt_q == CW'(3)) ? '0 : cnt_q + 1'b1;
      end
      ST_JOIN: begin
        if (adv) begin
          jidx_q <= jidx_q + 1'b1;
          cnt_q  <= (cnt_q == CW'(JOIN_SEGMENTS)) ? '0 : cnt_q + 1'b1;
          if (cnt_q != '0) begin
            if ({1'b0, frac_q} + (FW+1)'(PhRem) >= (FW+1)'(JOIN_SEGMENTS)) begin
              frac_q <= FW'({1'b0, frac_q} + (FW+1)'(PhRem) - (FW+1)'(JOIN_SEGMENTS));
              ph_q   <= ph_q + 5'(PhInc) + 5'd1;
            end else begin
              frac_q <= FW'({1'b0, frac_q} + (FW+1)'(PhRem));
              ph_q   <= ph_q + 5'(PhInc);
            end
          end
          if (cnt_q == CW'(JOIN_SEGMENTS)) begin
            close_q <= 1'b1;
            qa_x_q  <= cur_x_q;
            qa_y_q  <= cur_y_q;
            qb_x_q  <= first_x_q;
            qb_y_q  <= first_y_q;
            edge_q  <= vi_q;
          end
        end
      end
      default: cnt_q <= cnt_q;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// File: rtl/psg_checker.sv
// Port-level checks for the stroke geometry core, bound to the top level.
`include "polygon_stroke_geometry_core_defines.svh"

module psg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // one vertex in flight
  `PSG_ASSERT_NEXT(a_one_item, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // stalled request holds
  `PSG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))
  // join vertices never flag a degenerate edge
  `PSG_ASSERT_NOW(a_join_deg, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], !m_axis_tuser[1])
  // degenerate corners sit on whole pixels
  `PSG_ASSERT_NOW(a_deg_pixel, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1],
                  m_axis_tdata[3:0] == 4'd0 && m_axis_tdata[24:21] == 4'd0)

endmodule

bind polygon_stroke_geometry_core psg_checker u_psg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// File: bench/polygon_stroke_geometry_core_checker.sv
// Checker for the stroke geometry core: predicts output vertices and compares them.
`timescale 1ns / 1ps
module polygon_stroke_geometry_core_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [11:0] cfg_data_i,
  output int          fail_count,
  output int          pending_count
);

  localparam int unsigned MaxVert = psg_pkg::MaxVerticesDef;
  localparam int unsigned JoinSeg = psg_pkg::JoinSegmentsDef;
  localparam logic KindQuad = 1'b0;
  localparam logic KindJoin = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [20:0] vx;
    logic [20:0] vy;
    logic [17:0] idx;
    logic        deg;
    logic        lastr;
  } vtx_t;

  vtx_t        vtx_q[$];
  logic [11:0] width_r;
  int          first_x, first_y, prev_x, prev_y;
  int unsigned vert_cnt;
  bit          in_poly;

  function automatic int unit_sin(int unsigned k);
    int oct[9] = '{0, 3197, 6270, 9103, 11585, 13623, 15137, 16069, 16384};
    k = k % 32;
    if (k <= 8) return oct[k];
    if (k <= 16) return oct[16 - k];
    if (k <= 24) return -oct[k - 16];
    return -oct[32 - k];
  endfunction

  function automatic int circle_offset(int c, int unsigned h);
    longint m;
    int r;
    m = longint'(c < 0 ? -c : c) * h;
    r = int'((m + 16384) >>> 15);
    return c < 0 ? -r : r;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int normal_offset(int d, int unsigned h, longint unsigned len);
    longint unsigned m;
    int r;
    m = longint'(d < 0 ? -d : d) * h * 256;
    r = int'((m + len) / (2 * len));
    return d < 0 ? -r : r;
  endfunction

  function automatic void push_vtx(logic kind, int x, int y, int unsigned idx, logic deg);
    vtx_t v;
    v.kind  = kind;
    v.vx    = x[20:0];
    v.vy    = y[20:0];
    v.idx   = idx[17:0];
    v.deg   = deg;
    v.lastr = 1'b0;
    vtx_q   = {vtx_q, v};
  endfunction

  function automatic void predict_quad(int ax, int ay, int bx, int by, int unsigned edge_no);
    int dx, dy, ox, oy;
    logic deg;
    longint unsigned len;
    dx = bx - ax;
    dy = by - ay;
    ox = 0;
    oy = 0;
    deg = 1'b1;
    if (dx != 0 || dy != 0) begin
      len = int_sqrt((longint'(dx) * dx + longint'(dy) * dy) << 16);
      ox  = normal_offset(-dy, width_r, len);
      oy  = normal_offset(dx, width_r, len);
      deg = 1'b0;
    end
    push_vtx(KindQuad, ax * 16 + ox, ay * 16 + oy, edge_no * 4, deg);
    push_vtx(KindQuad, ax * 16 - ox, ay * 16 - oy, edge_no * 4 + 1, deg);
    push_vtx(KindQuad, bx * 16 + ox, by * 16 + oy, edge_no * 4 + 2, deg);
    push_vtx(KindQuad, bx * 16 - ox, by * 16 - oy, edge_no * 4 + 3, deg);
  endfunction

  function automatic void predict_vertex(logic [31:0] data, logic lastv);
    int x, y;
    int unsigned vi, ph;
    x  = int'($signed(data[15:0]));
    y  = int'($signed(data[31:16]));
    vi = in_poly ? vert_cnt % MaxVert : 0;
    if (in_poly) begin
      predict_quad(prev_x, prev_y, x, y, (vi + MaxVert - 1) % MaxVert);
    end else begin
      first_x = x;
      first_y = y;
    end
    push_vtx(KindJoin, x * 16, y * 16, vi * (JoinSeg + 1), 1'b0);
    for (int unsigned j = 1; j <= JoinSeg; j++) begin
      ph = ((j - 1) * 32) / JoinSeg;
      push_vtx(KindJoin, x * 16 + circle_offset(unit_sin(ph + 8), width_r),
               y * 16 + circle_offset(unit_sin(ph), width_r), vi * (JoinSeg + 1) + j, 1'b0);
    end
    if (lastv) begin
      predict_quad(x, y, first_x, first_y, vi);
      in_poly  = 1'b0;
      vert_cnt = 0;
    end else begin
      in_poly  = 1'b1;
      vert_cnt = (vi + 1) % MaxVert;
    end
    prev_x = x;
    prev_y = y;
    vtx_q[$].lastr = 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vtx_t want;
    if (!rst_ni) begin
      width_r       = psg_pkg::StrokeWidthRst;
      first_x       = 0;
      first_y       = 0;
      prev_x        = 0;
      prev_y        = 0;
      vert_cnt      = 0;
      in_poly       = 1'b0;
      fail_count    = 0;
      vtx_q.delete();
      pending_count = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (vtx_q.size() == 0) begin
          report_mismatch("unexpected vertex", m_axis_tdata, '0);
        end else begin
          want = vtx_q.pop_front();
          if (m_axis_tuser[0] !== want.kind)
            report_mismatch("vertex_kind", m_axis_tuser[0], want.kind);
          if (m_axis_tdata[20:0] !== want.vx) report_mismatch("vx", m_axis_tdata[20:0], want.vx);
          if (m_axis_tdata[41:21] !== want.vy) report_mismatch("vy", m_axis_tdata[41:21], want.vy);
          if (m_axis_tdata[59:42] !== want.idx)
            report_mismatch("vertex_index", m_axis_tdata[59:42], want.idx);
          if (m_axis_tuser[1] !== want.deg)
            report_mismatch("degenerate_edge", m_axis_tuser[1], want.deg);
          if (m_axis_tlast !== want.lastr)
            report_mismatch("last_result", m_axis_tlast, want.lastr);
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_vertex(s_axis_tdata, s_axis_tlast);
      if (cfg_valid_i && cfg_ready_o) width_r = cfg_data_i;
      pending_count = vtx_q.size();
    end
  end

endmodule

// File: bench/polygon_stroke_geometry_core_tb.sv
// Testbench top for the stroke geometry core: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module polygon_stroke_geometry_core_tb;

  localparam int WatchdogMax = 20000;
  localparam int DrainCycles = 200;
  localparam int HoldLen     = 3000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [11:0] cfg_data_i;
  int          fail_count;
  int          pending_count;
  int          idle_pct;
  int          hold_cycles;
  int          quiet_cycles;
  logic        hold_req;

  polygon_stroke_geometry_core u_dut (.*);

  polygon_stroke_geometry_core_checker u_checker (.*);

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // receiver: random stalls, plus an explicit long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= 0;
    end else if (hold_req) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= HoldLen;
    end else if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogMax) begin
      $display("polygon_stroke_geometry_core_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ready only changes at the rising edge, so it is sampled at the falling edge
  task automatic send_vertex(int x, int y, bit lastv);
    @(posedge clk_i);
    while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y[15:0], x[15:0]};
    s_axis_tlast  <= lastv;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_width(logic [11:0] w);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= w;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // random polygon: mostly small coordinates, sometimes full range
  task automatic send_polygon(int nverts);
    int cx, cy, span;
    cx   = $urandom_range(2000) - 1000;
    cy   = $urandom_range(2000) - 1000;
    span = ($urandom_range(9) == 0) ? 65535 : $urandom_range(300);
    for (int i = 0; i < nverts; i++) begin
      if (span == 65535)
        send_vertex($urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                    i == nverts - 1);
      else
        send_vertex(cx + $urandom_range(2 * span) - span, cy + $urandom_range(2 * span) - span,
                    i == nverts - 1);
    end
  endtask

  initial begin
    int sent;
    idle_pct      = 34;
    hold_req      = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes at reset width, single vertex, zero-length edge, then widths 0, max and 1
    send_vertex(32767, 32767, 1'b0);
    send_vertex(-32768, -32768, 1'b0);
    send_vertex(-32768, -32768, 1'b0);
    send_vertex(32767, -32768, 1'b1);
    send_vertex(5, -7, 1'b1);
    send_vertex(0, 0, 1'b0);
    send_vertex(-1, 0, 1'b0);
    send_vertex(0, -1, 1'b1);
    write_width(12'd0);
    send_vertex(100, 100, 1'b0);
    send_vertex(300, -50, 1'b1);
    write_width(12'hFFF);
    send_vertex(-32768, 32767, 1'b0);
    send_vertex(32767, 32767, 1'b0);
    send_vertex(32767, -32768, 1'b0);
    send_vertex(-32768, -32768, 1'b1);
    send_vertex(0, 0, 1'b1);
    write_width(12'd1);
    send_vertex(1, 2, 1'b0);
    send_vertex(3, 4, 1'b1);
    sent = 18;

    // long stretch with no idling
    write_width(12'd160);
    idle_pct = 0;
    while (sent < 120) begin
      send_polygon($urandom_range(6, 1));
      sent = sent + 6;
    end
    idle_pct = 34;

    // receiver holds off while the sender keeps offering
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    send_polygon(8);
    sent = sent + 8;
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      write_width(phase == 3 ? 12'hFFF : 12'($urandom_range(4095)));
      repeat (25) begin
        send_polygon($urandom_range(6, 1));
        sent = sent + 3;
      end
    end

    // one long polygon to exercise deep vertex counts
    for (int i = 0; i < 60; i++)
      send_vertex($urandom_range(65535) - 32768, $urandom_range(65535) - 32768, i == 59);

    wait_drained();
    if (fail_count == 0) begin
      $display("polygon_stroke_geometry_core_tb: done, clean");
    end else begin
      $display("polygon_stroke_geometry_core_tb: done, errors");
    end
    $finish;
  end

endmodule
